// File: rtl/qfr_pkg.sv
// ----------------------------------------------------------------------------
// qfr_pkg
// Shared widths and codes for the rotation-matrix-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package qfr_pkg;

    // Width of every matrix element and quaternion component.
    localparam int ELEM_W = 16;

    // Magnitude width of an off-diagonal sum or difference (up to 65536).
    localparam int MAG_W = 17;

    // Which component the square root belongs to.
    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } sel_t;

endpackage

// File: rtl/qfr_sqrt.sv
// ----------------------------------------------------------------------------
// qfr_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qfr_sqrt #(
    parameter int VW = 32,
    parameter int QW = 16,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [VW-1:0] in_v,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_root,
    output logic [PW-1:0] out_pay
);

    localparam int PADW = 2 * QW;

    logic [PADW-1:0] v_s    [QW+1];
    logic [QW+1:0]   rem_s  [QW+1];
    logic [QW-1:0]   root_s [QW+1];
    logic [PW-1:0]   pay_s  [QW+1];
    logic            vld_s  [QW+1];

    assign v_s[0]    = PADW'(in_v);
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign pay_s[0]  = in_pay;
    assign vld_s[0]  = in_valid;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [QW+1:0] cur;
        logic [QW+1:0] trial;
        logic          ge;
        logic [PADW-1:0] v_reg;
        logic [QW+1:0]   rem_reg;
        logic [QW-1:0]   root_reg;
        logic [PW-1:0]   pay_reg;
        logic            vld_reg;

        // The partial remainder stays below 2^QW before the last step.
        assign cur   = {rem_s[k][QW-1:0], v_s[k][PADW-1 -: 2]};
        assign trial = {root_s[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_s[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg    <= v_s[k] << 2;
                rem_reg  <= ge ? (cur - trial) : cur;
                root_reg <= {root_s[k][QW-2:0], ge};
                pay_reg  <= pay_s[k];
            end
        end

        assign v_s[k+1]    = v_reg;
        assign rem_s[k+1]  = rem_reg;
        assign root_s[k+1] = root_reg;
        assign pay_s[k+1]  = pay_reg;
        assign vld_s[k+1]  = vld_reg;
    end

    assign out_valid = vld_s[QW];
    assign out_root  = root_s[QW];
    assign out_pay   = pay_s[QW];

endmodule

// File: rtl/qfr_div.sv
// ----------------------------------------------------------------------------
// qfr_div
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
module qfr_div #(
    parameter int NW = 32,
    parameter int SW = 17,
    parameter int PW = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0][NW-1:0] in_num,
    input  logic [SW-1:0]      in_den,
    input  logic [PW-1:0]      in_pay,
    output logic               out_valid,
    output logic [2:0][NW-1:0] out_quo,
    output logic [PW-1:0]      out_pay
);

    logic [2:0][NW-1:0] num_s [NW+1];
    logic [2:0][SW-1:0] rem_s [NW+1];
    logic [2:0][NW-1:0] quo_s [NW+1];
    logic [SW-1:0]      den_s [NW+1];
    logic [PW-1:0]      pay_s [NW+1];
    logic               vld_s [NW+1];

    assign num_s[0] = in_num;
    assign rem_s[0] = '0;
    assign quo_s[0] = '0;
    assign den_s[0] = in_den;
    assign pay_s[0] = in_pay;
    assign vld_s[0] = in_valid;

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [2:0][NW-1:0] num_reg;
        logic [2:0][SW-1:0] rem_reg;
        logic [2:0][NW-1:0] quo_reg;
        logic [SW-1:0]      den_reg;
        logic [PW-1:0]      pay_reg;
        logic               vld_reg;
        logic [2:0][SW-1:0] rem_next;
        logic [2:0]         ge;

        always_comb begin
            logic [SW:0] cur;
            for (int j = 0; j < 3; j++) begin
                cur         = {rem_s[k][j], num_s[k][j][NW-1]};
                ge[j]       = (cur >= {1'b0, den_s[k]});
                rem_next[j] = ge[j] ? SW'(cur - {1'b0, den_s[k]}) : cur[SW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_s[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int j = 0; j < 3; j++) begin
                    num_reg[j] <= num_s[k][j] << 1;
                    quo_reg[j] <= {quo_s[k][j][NW-2:0], ge[j]};
                end
                rem_reg <= rem_next;
                den_reg <= den_s[k];
                pay_reg <= pay_s[k];
            end
        end

        assign num_s[k+1] = num_reg;
        assign rem_s[k+1] = rem_reg;
        assign quo_s[k+1] = quo_reg;
        assign den_s[k+1] = den_reg;
        assign pay_s[k+1] = pay_reg;
        assign vld_s[k+1] = vld_reg;
    end

    assign out_valid = vld_s[NW];
    assign out_quo   = quo_s[NW];
    assign out_pay   = pay_s[NW];

endmodule

// File: rtl/quaternion_from_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix
// Converts a 3x3 rotation matrix into a quaternion by Shepperd's method.
// ----------------------------------------------------------------------------
// Stages: the input register, the one-bit-per-stage square root (QW stages,
//   16 at FRAC_BITS = 14), the one-bit-per-stage divider (NW stages, 32 at
//   FRAC_BITS = 14) and the output register.
// Throughput: one transfer per cycle; the whole pipeline holds when a result
//   waits in the output register and m_tready is low.
// Reset: aresetn is synchronous and active low; it clears all valid bits.
module quaternion_from_rotation_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 16 bits each.
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up, 16 bits each.
    output logic [63:0]  m_tdata
);

    localparam int EW  = qfr_pkg::ELEM_W;
    localparam int MW  = qfr_pkg::MAG_W;
    // Signed width of the radicand, and its unsigned width once clamped.
    localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int UW  = RW - 1;
    // Width of the scaled radicand and of its root.
    localparam int VW  = UW + FRAC_BITS;
    localparam int QW  = (VW + 1) / 2;
    // Divisor S = 2 * root and the numerator (n << FRAC_BITS) + root.
    localparam int SW  = QW + 1;
    localparam int NW  = MW + FRAC_BITS + 1;
    // Saturation bounds; the negative bound is held as a magnitude.
    localparam int HI  = (FRAC_BITS >= 15) ? 32767 : (2 ** FRAC_BITS);
    localparam int LOM = (FRAC_BITS >= 15) ? 32768 : (2 ** FRAC_BITS);
    localparam int SPW = 2 + 3 + 3 * MW;
    localparam int DPW = 2 + 3 + QW;

    // The whole pipeline moves together; the output register is the only
    // place a finished result waits.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------- prep
    // The branch is picked from the trace and the diagonal, and each of the
    // three other components gets its off-diagonal numerator as sign and
    // magnitude, in w, x, y, z order with the branch component skipped.
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    assign m00 = s_tdata[0*EW +: EW];
    assign m01 = s_tdata[1*EW +: EW];
    assign m02 = s_tdata[2*EW +: EW];
    assign m10 = s_tdata[3*EW +: EW];
    assign m11 = s_tdata[4*EW +: EW];
    assign m12 = s_tdata[5*EW +: EW];
    assign m20 = s_tdata[6*EW +: EW];
    assign m21 = s_tdata[7*EW +: EW];
    assign m22 = s_tdata[8*EW +: EW];

    qfr_pkg::sel_t      sel_next;
    logic [UW-1:0]      rad_next;
    logic [2:0]         sgn_next;
    logic [2:0][MW-1:0] mag_next;

    always_comb begin
        logic signed [RW-1:0] e00, e11, e22, one, tr, rad;
        logic signed [MW-1:0] dwx, dwy, dwz, pxy, pxz, pyz;
        logic signed [MW-1:0] n [3];
        e00 = RW'(m00);
        e11 = RW'(m11);
        e22 = RW'(m22);
        one = RW'(1) <<< FRAC_BITS;
        tr  = e00 + e11 + e22;
        dwx = MW'(m21) - MW'(m12);
        dwy = MW'(m02) - MW'(m20);
        dwz = MW'(m10) - MW'(m01);
        pxy = MW'(m01) + MW'(m10);
        pxz = MW'(m02) + MW'(m20);
        pyz = MW'(m12) + MW'(m21);
        if (tr > 0) begin
            sel_next = qfr_pkg::SEL_W;
            rad      = one + tr;
            n[0] = dwx; n[1] = dwy; n[2] = dwz;
        end else if (m00 > m11 && m00 > m22) begin
            sel_next = qfr_pkg::SEL_X;
            rad      = one + e00 - e11 - e22;
            n[0] = dwx; n[1] = pxy; n[2] = pxz;
        end else if (m11 > m22) begin
            sel_next = qfr_pkg::SEL_Y;
            rad      = one + e11 - e00 - e22;
            n[0] = dwy; n[1] = pxy; n[2] = pyz;
        end else begin
            sel_next = qfr_pkg::SEL_Z;
            rad      = one + e22 - e00 - e11;
            n[0] = dwz; n[1] = pxz; n[2] = pyz;
        end
        // A radicand below zero only comes from a matrix that is no rotation.
        rad_next = rad[RW-1] ? '0 : rad[UW-1:0];
        for (int j = 0; j < 3; j++) begin
            sgn_next[j] = n[j][MW-1];
            mag_next[j] = n[j][MW-1] ? MW'(-n[j]) : MW'(n[j]);
        end
    end

    logic               prep_vld_reg;
    qfr_pkg::sel_t      prep_sel_reg;
    logic [UW-1:0]      prep_rad_reg;
    logic [2:0]         prep_sgn_reg;
    logic [2:0][MW-1:0] prep_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (en) begin
            prep_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_sel_reg <= sel_next;
            prep_rad_reg <= rad_next;
            prep_sgn_reg <= sgn_next;
            prep_mag_reg <= mag_next;
        end
    end

    // -------------------------------------------------------- square root
    logic           sq_vld;
    logic [QW-1:0]  sq_root;
    logic [SPW-1:0] sq_pay;

    qfr_sqrt #(.VW(VW), .QW(QW), .PW(SPW)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_vld_reg),
        .in_v      ({prep_rad_reg, {FRAC_BITS{1'b0}}}),
        .in_pay    ({prep_sel_reg, prep_sgn_reg, prep_mag_reg}),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_pay   (sq_pay)
    );

    // ------------------------------------------------------------ divider
    // Adding the root (S / 2) to the scaled numerator rounds the quotient
    // to nearest, ties away from zero, once the sign is put back.
    logic               sq_sel;
    logic [2:0]         sq_sgn;
    logic [2:0][MW-1:0] sq_mag;
    logic [2:0][NW-1:0] div_num;

    assign sq_sgn = sq_pay[3*MW +: 3];
    assign sq_mag = sq_pay[3*MW-1:0];
    assign sq_sel = 1'b0;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            div_num[j] = (NW'(sq_mag[j]) << FRAC_BITS) + NW'(sq_root);
        end
    end

    logic               dv_vld;
    logic [2:0][NW-1:0] dv_quo;
    logic [DPW-1:0]     dv_pay;

    qfr_div #(.NW(NW), .SW(SW), .PW(DPW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_vld),
        .in_num    (div_num),
        .in_den    ({sq_root, sq_sel}),
        .in_pay    ({sq_pay[SPW-1 -: 2], sq_sgn, sq_root}),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_pay   (dv_pay)
    );

    // ---------------------------------------------------- saturate, output
    function automatic logic [EW-1:0] sat_comp(input logic neg, input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        logic [NW-1:0] m;
        lim = neg ? NW'(LOM) : NW'(HI);
        m   = (mag > lim) ? lim : mag;
        return neg ? (EW'(0) - m[EW-1:0]) : m[EW-1:0];
    endfunction

    qfr_pkg::sel_t  dv_sel;
    logic [2:0]     dv_sgn;
    logic [QW-1:0]  dv_root;
    logic [QW:0]    big_sum;
    logic [EW-1:0]  big;
    logic [EW-1:0]  q [3];
    logic [63:0]    out_next;

    assign dv_sel  = qfr_pkg::sel_t'(dv_pay[DPW-1 -: 2]);
    assign dv_sgn  = dv_pay[QW +: 3];
    assign dv_root = dv_pay[QW-1:0];
    assign big_sum = {1'b0, dv_root} + (QW+1)'(1);
    assign big     = sat_comp(1'b0, NW'(big_sum[QW:1]));

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            // A zero S gives zero quotients.
            q[j] = (dv_root == '0) ? '0 : sat_comp(dv_sgn[j], dv_quo[j]);
        end
        case (dv_sel)
            qfr_pkg::SEL_W: out_next = {q[2], q[1], q[0], big};
            qfr_pkg::SEL_X: out_next = {q[2], q[1], big, q[0]};
            qfr_pkg::SEL_Y: out_next = {q[2], big, q[1], q[0]};
            qfr_pkg::SEL_Z: out_next = {big, q[2], q[1], q[0]};
            default:        out_next = '0;
        endcase
    end

    logic        out_vld_reg;
    logic [63:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/qfr_checker.sv
// ----------------------------------------------------------------------------
// qfr_checker
// Port-level checks on the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
module qfr_checker #(
    parameter int FRAC_BITS = 14
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    localparam int HI  = (FRAC_BITS >= 15) ? 32767 : (2 ** FRAC_BITS);
    localparam int LOM = (FRAC_BITS >= 15) ? 32768 : (2 ** FRAC_BITS);

    function automatic logic in_range(input logic signed [15:0] v);
        return (int'(v) <= HI) && (int'(v) >= -LOM);
    endfunction

    // A result waiting on the output holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Nothing leaves the block right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The input side is open whenever the output register is empty.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // Every component stays within the saturation bounds.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> in_range(m_tdata[15:0]) && in_range(m_tdata[31:16])
                  && in_range(m_tdata[47:32]) && in_range(m_tdata[63:48]))
        else $error("component out of range");

endmodule

bind quaternion_from_rotation_matrix qfr_checker #(.FRAC_BITS(FRAC_BITS)) u_qfr_checker (.*);
